// File: rtl/core/lhcb_pkg.sv
// Shared types and constants for the letter Huffman code builder.
`default_nettype none
package lhcb_pkg;
    localparam int LETTER_W = 5;
    localparam int CODE_W = 25;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                present;
        logic [LETTER_W-1:0] len;
        logic [CODE_W-1:0]   bits;
        logic                fin;
    } res_item_t;

    // Map a byte to a case-folded letter number; returns valid flag in bit 5.
    function automatic logic [5:0] letter_of(input logic [7:0] b);
        logic [5:0] r;
        r = 6'd0;
        if (b >= 8'h41 && b <= 8'h5a) r = {1'b1, 5'(b - 8'h41)};
        else if (b >= 8'h61 && b <= 8'h7a) r = {1'b1, 5'(b - 8'h61)};
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/lhcb_front.sv
// Front end: takes bytes and queues them for the builder.
`default_nettype none
module lhcb_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lhcb_pkg::in_item_t in_item,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output lhcb_pkg::in_item_t     q_item
);
    lhcb_pkg::in_item_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_reg] <= in_item;
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/lhcb_back.sv
// Back end: letter counters, tree build and code emission.
`default_nettype none
module lhcb_back #(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire lhcb_pkg::in_item_t q_item,
    output logic                    r_valid,
    input  wire logic               r_ready,
    output lhcb_pkg::res_item_t     r_item
);
    localparam int NODES = 2 * ALPHABET_SIZE - 1;
    localparam int NW = $clog2(NODES + 1);
    localparam int WW = COUNT_BITS + $clog2(ALPHABET_SIZE) + 1;
    localparam int LW = lhcb_pkg::LETTER_W;
    localparam int LIW = $clog2(ALPHABET_SIZE);
    localparam int INNER = ALPHABET_SIZE - 1;
    localparam int IIW = (INNER > 1) ? $clog2(INNER) : 1;
    localparam logic [NW-1:0] FIRST_INNER = NW'(ALPHABET_SIZE);
    localparam logic [NW-1:0] LAST_NODE = NW'(NODES);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [2:0] S_COUNT = 3'd0, S_INIT = 3'd1, S_PICK = 3'd2,
                           S_WALK = 3'd3, S_OUT = 3'd4;

    logic [2:0] st_reg, st_next;
    logic [COUNT_BITS-1:0] cnt_reg [ALPHABET_SIZE];
    logic [WW-1:0] iw_reg [INNER];
    logic [NW-1:0] lpar_reg [ALPHABET_SIZE];
    logic [NW-1:0] ipar_reg [INNER];
    logic [NODES-1:0] rt_reg, un_reg;
    logic [NW-1:0] idx_reg, nxt_reg, lo_reg, root_reg, node_reg;
    logic [WW-1:0] lo_w_reg;
    logic [NW-1:0] active_reg;
    logic          second_reg;
    logic [LW-1:0] len_reg;
    logic [lhcb_pkg::CODE_W-1:0] bits_reg;
    logic [NW-1:0] let_reg;
    logic          out_v_reg;
    lhcb_pkg::res_item_t out_reg;
    logic [5:0]    lt;
    logic          best_f;
    logic [NW-1:0] best_i;
    logic [WW-1:0] best_w;
    logic [WW-1:0] scan_w;
    logic [NW-1:0] up_node;

    assign lt = lhcb_pkg::letter_of(q_item.data);
    assign q_ready = (st_reg == S_COUNT);
    assign r_valid = out_v_reg;
    assign r_item  = out_reg;

    // leaves weigh their counters; merged nodes keep their sums in iw_reg
    always_comb begin
        if (idx_reg < FIRST_INNER) scan_w = WW'(cnt_reg[idx_reg[LIW-1:0]]);
        else scan_w = iw_reg[IIW'(idx_reg - FIRST_INNER)];
    end

    always_comb begin
        if (node_reg < FIRST_INNER) up_node = lpar_reg[node_reg[LIW-1:0]];
        else up_node = ipar_reg[IIW'(node_reg - FIRST_INNER)];
    end

    // scan one node per cycle for the minimum: idx_reg walks nodes
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_COUNT: if (q_valid && q_item.last) st_next = S_INIT;
            S_INIT:  st_next = S_PICK;
            S_PICK:  st_next = S_PICK;
            S_WALK:  st_next = S_WALK;
            S_OUT:   st_next = S_OUT;
            default: st_next = S_COUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_COUNT;
            out_v_reg <= 1'b0;
            un_reg    <= '0;
            for (int i = 0; i < ALPHABET_SIZE; i++) cnt_reg[i] <= '0;
        end else begin
            if (out_v_reg && r_ready) out_v_reg <= 1'b0;
            unique case (st_reg)
                S_COUNT: begin
                    if (q_valid) begin
                        if (lt[5] && {1'b0, lt[4:0]} < 6'(ALPHABET_SIZE)
                            && cnt_reg[lt[4:0]] != CMAX)
                            cnt_reg[lt[4:0]] <= cnt_reg[lt[4:0]] + 1'b1;
                        if (q_item.last) st_reg <= S_INIT;
                    end
                end
                S_INIT: begin
                    un_reg <= '0;
                    for (int i = 0; i < ALPHABET_SIZE; i++)
                        un_reg[i] <= (cnt_reg[i] != '0);
                    active_reg <= '0;
                    idx_reg <= '0;
                    nxt_reg <= FIRST_INNER;
                    second_reg <= 1'b0;
                    best_f <= 1'b0;
                    root_reg <= LAST_NODE;
                    st_reg <= S_PICK;
                end
                S_PICK: begin
                    // count leaves during first scan via active_reg when nxt is first
                    if (idx_reg < nxt_reg) begin
                        if (nxt_reg == FIRST_INNER && !second_reg && un_reg[idx_reg])
                            active_reg <= active_reg + 1'b1;
                        if (un_reg[idx_reg] && (!best_f || scan_w < best_w)) begin
                            best_f <= 1'b1;
                            best_i <= idx_reg;
                            best_w <= scan_w;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        idx_reg <= '0;
                        best_f <= 1'b0;
                        if (!best_f) begin
                            // nothing left beside the first pick: that node is the root
                            if (second_reg) root_reg <= lo_reg;
                            st_reg <= S_WALK; let_reg <= '0; node_reg <= '0;
                            len_reg <= '0; bits_reg <= '0;
                        end else if (!second_reg) begin
                            if (nxt_reg == FIRST_INNER && active_reg == NW'(1)
                                || nxt_reg == LAST_NODE) begin
                                root_reg <= best_i;
                                st_reg <= S_WALK; let_reg <= '0; node_reg <= '0;
                                len_reg <= '0; bits_reg <= '0;
                            end else begin
                                un_reg[best_i] <= 1'b0;
                                lo_reg <= best_i;
                                lo_w_reg <= best_w;
                                second_reg <= 1'b1;
                            end
                        end else begin
                            un_reg[best_i] <= 1'b0;
                            un_reg[nxt_reg] <= 1'b1;
                            iw_reg[IIW'(nxt_reg - FIRST_INNER)] <= lo_w_reg + best_w;
                            if (lo_reg < FIRST_INNER) lpar_reg[lo_reg[LIW-1:0]] <= nxt_reg;
                            else ipar_reg[IIW'(lo_reg - FIRST_INNER)] <= nxt_reg;
                            if (best_i < FIRST_INNER) lpar_reg[best_i[LIW-1:0]] <= nxt_reg;
                            else ipar_reg[IIW'(best_i - FIRST_INNER)] <= nxt_reg;
                            rt_reg[lo_reg] <= 1'b0;
                            rt_reg[best_i] <= 1'b1;
                            nxt_reg <= nxt_reg + 1'b1;
                            second_reg <= 1'b0;
                        end
                    end
                end
                S_WALK: begin
                    // climb one level per cycle from the leaf to the root
                    if (cnt_reg[let_reg[LIW-1:0]] == '0 || node_reg == root_reg) begin
                        if (!out_v_reg || r_ready) begin
                            out_v_reg <= 1'b1;
                            out_reg.letter  <= LW'(let_reg);
                            out_reg.present <= (cnt_reg[let_reg[LIW-1:0]] != '0);
                            out_reg.len     <= len_reg;
                            out_reg.bits    <= bits_reg;
                            out_reg.fin     <= (let_reg == NW'(ALPHABET_SIZE - 1));
                            st_reg <= S_OUT;
                        end
                    end else begin
                        bits_reg <= bits_reg | (lhcb_pkg::CODE_W'(rt_reg[node_reg]) << len_reg);
                        len_reg  <= len_reg + 1'b1;
                        node_reg <= up_node;
                    end
                end
                S_OUT: begin
                    if (let_reg == NW'(ALPHABET_SIZE - 1)) begin
                        for (int i = 0; i < ALPHABET_SIZE; i++) cnt_reg[i] <= '0;
                        st_reg <= S_COUNT;
                    end else begin
                        let_reg  <= let_reg + 1'b1;
                        node_reg <= let_reg + 1'b1;
                        len_reg  <= '0;
                        bits_reg <= '0;
                        st_reg   <= S_WALK;
                    end
                end
                default: st_reg <= st_next;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/letter_huffman_code_builder_unit.sv
// Top level of the letter Huffman code builder.
// Usage:
//   s_axis carries text bytes, one per cycle while the builder counts.
//   tdata = text_byte, tlast = end_of_text.
//   A byte with tlast starts the tree build; then 26 result items leave on
//   m_axis in letter order, tlast on letter z.
//   m_tdata = {code_bits, code_length, letter_index}, letter_index at bit 0;
//   m_tuser = present.
// Throughput:
//   Counting takes one byte per cycle. The build scans one node per cycle:
//   a pick scans every node slot made so far, two picks per merge, so the
//   build time is set by the sequential min-scan.
//   Each result then climbs from its leaf to the root, one tree level a cycle.
//   A two-entry input queue keeps taking bytes while the back end is busy
//   until it fills.
// Reset clears counters and control; the tree arrays need no reset.
// A stalled receiver holds the current result and halts emission.
`default_nettype none
module letter_huffman_code_builder_unit #(
    parameter int ALPHABET_SIZE = 26,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // letter_index[4:0], code_length[9:5], code_bits[34:10]
    output logic             m_tuser,   // present
    output logic             m_tlast    // final_result
);
    lhcb_pkg::in_item_t  in_item, q_item;
    lhcb_pkg::res_item_t r_item;
    logic q_valid, q_ready;

    assign in_item.data = s_tdata;
    assign in_item.last = s_tlast;

    lhcb_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    lhcb_back #(.ALPHABET_SIZE(ALPHABET_SIZE), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_item(r_item)
    );

    assign m_tdata = {5'd0, r_item.bits, r_item.len, r_item.letter};
    assign m_tuser = r_item.present;
    assign m_tlast = r_item.fin;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[9:5] == 5'd0)
        else $error("absent letter has a code");
endmodule
`default_nettype wire
